>>> sv/kpar_pkg.sv
// Shared types and constants for the key pair axis ramp block.
// No dependencies; every other file refers to it by scoped names.
package kpar_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned AXIS_W    = 10;
  // Headroom for axis plus or minus the widest step
  localparam int unsigned AXIS_EXT_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [TIMER_W-1:0] RELEASE_MS  = 16'd150;
  localparam logic [TIMER_W-1:0] TIMER_RESET = 16'd9999;
  localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;
  localparam logic [STEP_W-1:0]  DEFAULT_STEP = 10'd16;
  localparam logic signed [AXIS_EXT_W-1:0] AXIS_LIMIT = 12'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITIVE_KEY = 2'd0,
    REG_NEGATIVE_KEY = 2'd1,
    REG_STEP_SIZE    = 2'd2,
    REG_AUTO_RETURN  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

endpackage

>>> sv/kpar_in_if.sv
// Input request channel: valid/ready handshake with byte or tick payload.
// Depends on kpar_pkg for field widths.
interface kpar_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [kpar_pkg::KEY_W-1:0]   rx_byte;
  logic [kpar_pkg::TIMER_W-1:0] elapsed_ms;

  modport source (output valid, cmd, rx_byte, elapsed_ms, input ready);
  modport sink   (input valid, cmd, rx_byte, elapsed_ms, output ready);
endinterface

>>> sv/kpar_out_if.sv
// Result channel: valid/ready handshake carrying axis value and held flags.
// Depends on kpar_pkg for field widths.
interface kpar_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [kpar_pkg::AXIS_W-1:0] axis_out;
  logic                              pos_held;
  logic                              neg_held;

  modport source (output valid, axis_out, pos_held, neg_held, input ready);
  modport sink   (input valid, axis_out, pos_held, neg_held, output ready);
endinterface

>>> sv/key_pair_axis_ramp.sv
// The result of an accepted request is registered and shows in the cycle after it is accepted.
// Throughput: one request per cycle while each result is taken; a single result register lets
// the input accept a new request in the same cycle the waiting result is taken.
// Reset (rst_n, synchronous, active low): axis 0, both keys released, both
// elapsed counters 9999, keys 0, step 16, auto-return off, no result pending.
// Depends on kpar_pkg, kpar_in_if and kpar_out_if.
module key_pair_axis_ramp (
  input  logic                             clk,
  input  logic                             rst_n,
  kpar_in_if.sink                          in_if,
  kpar_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [kpar_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kpar_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic [kpar_pkg::KEY_W-1:0]  pos_key_r;
  logic [kpar_pkg::KEY_W-1:0]  neg_key_r;
  logic [kpar_pkg::STEP_W-1:0] step_size_r;
  logic                        auto_return_r;

  // Block state
  logic signed [kpar_pkg::AXIS_W-1:0] axis_r, axis_nxt;
  logic [kpar_pkg::TIMER_W-1:0]       pos_timer_r, pos_timer_nxt;
  logic [kpar_pkg::TIMER_W-1:0]       neg_timer_r, neg_timer_nxt;
  logic                               pos_down_r, pos_down_nxt;
  logic                               neg_down_r, neg_down_nxt;

  // Result register
  logic                               out_valid_r;
  logic signed [kpar_pkg::AXIS_W-1:0] out_axis_r;
  logic                               out_pos_r;
  logic                               out_neg_r;

  logic in_acc;

  // Tick datapath
  logic [kpar_pkg::TIMER_W:0]             pos_sum, neg_sum;
  logic [kpar_pkg::TIMER_W-1:0]           pos_sat, neg_sat;
  logic                                   pos_tick, neg_tick;
  logic [kpar_pkg::STEP_W-1:0]            step_eff;
  logic signed [kpar_pkg::AXIS_EXT_W-1:0] axis_ext, step_ext, up_val, dn_val;

  // Accept whenever the result register is empty or being drained this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  assign out_if.valid    = out_valid_r;
  assign out_if.axis_out = out_axis_r;
  assign out_if.pos_held = out_pos_r;
  assign out_if.neg_held = out_neg_r;

  // Configuration writes; every index value names one of the four registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_key_r     <= '0;
      neg_key_r     <= '0;
      step_size_r   <= kpar_pkg::DEFAULT_STEP;
      auto_return_r <= 1'b0;
    end else if (cfg_we) begin
      case (kpar_pkg::cfg_reg_t'(cfg_idx))
        kpar_pkg::REG_POSITIVE_KEY: pos_key_r     <= cfg_wdata[kpar_pkg::KEY_W-1:0];
        kpar_pkg::REG_NEGATIVE_KEY: neg_key_r     <= cfg_wdata[kpar_pkg::KEY_W-1:0];
        kpar_pkg::REG_STEP_SIZE:    step_size_r   <= cfg_wdata[kpar_pkg::STEP_W-1:0];
        kpar_pkg::REG_AUTO_RETURN:  auto_return_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Tick arithmetic: saturating counters, then release, then axis step
  always_comb begin
    pos_sum  = {1'b0, pos_timer_r} + {1'b0, in_if.elapsed_ms};
    neg_sum  = {1'b0, neg_timer_r} + {1'b0, in_if.elapsed_ms};
    // Clamp at the counter ceiling rather than wrap
    pos_sat  = pos_sum[kpar_pkg::TIMER_W] ? kpar_pkg::TIMER_MAX
                                          : pos_sum[kpar_pkg::TIMER_W-1:0];
    neg_sat  = neg_sum[kpar_pkg::TIMER_W] ? kpar_pkg::TIMER_MAX
                                          : neg_sum[kpar_pkg::TIMER_W-1:0];
    pos_tick = pos_down_r && !(pos_sat > kpar_pkg::RELEASE_MS);
    neg_tick = neg_down_r && !(neg_sat > kpar_pkg::RELEASE_MS);

    // A zero step falls back to the default
    step_eff = (step_size_r == '0) ? kpar_pkg::DEFAULT_STEP : step_size_r;
    axis_ext = kpar_pkg::AXIS_EXT_W'(axis_r);
    step_ext = $signed({{(kpar_pkg::AXIS_EXT_W-kpar_pkg::STEP_W){1'b0}}, step_eff});
    up_val   = axis_ext + step_ext;
    dn_val   = axis_ext - step_ext;
  end

  // Next state for the request at the input
  always_comb begin
    axis_nxt      = axis_r;
    pos_timer_nxt = pos_timer_r;
    neg_timer_nxt = neg_timer_r;
    pos_down_nxt  = pos_down_r;
    neg_down_nxt  = neg_down_r;
    case (kpar_pkg::cmd_t'(in_if.cmd))
      kpar_pkg::CMD_BYTE: begin
        // Positive key wins when both keys share a code
        if (in_if.rx_byte == pos_key_r) begin
          pos_down_nxt  = 1'b1;
          pos_timer_nxt = '0;
        end else if (in_if.rx_byte == neg_key_r) begin
          neg_down_nxt  = 1'b1;
          neg_timer_nxt = '0;
        end
      end
      kpar_pkg::CMD_TICK: begin
        pos_timer_nxt = pos_sat;
        neg_timer_nxt = neg_sat;
        pos_down_nxt  = pos_tick;
        neg_down_nxt  = neg_tick;
        if (pos_tick && !neg_tick) begin
          // Ramp up, clamp at the upper limit
          axis_nxt = (up_val > kpar_pkg::AXIS_LIMIT) ? kpar_pkg::AXIS_W'(kpar_pkg::AXIS_LIMIT)
                                                     : kpar_pkg::AXIS_W'(up_val);
        end else if (neg_tick && !pos_tick) begin
          // Ramp down, clamp at the lower limit
          axis_nxt = (dn_val < -kpar_pkg::AXIS_LIMIT) ? kpar_pkg::AXIS_W'(-kpar_pkg::AXIS_LIMIT)
                                                      : kpar_pkg::AXIS_W'(dn_val);
        end else if (auto_return_r) begin
          // Return toward zero without passing it
          if (axis_r > 0) begin
            axis_nxt = (dn_val < 0) ? '0 : kpar_pkg::AXIS_W'(dn_val);
          end else if (axis_r < 0) begin
            axis_nxt = (up_val > 0) ? '0 : kpar_pkg::AXIS_W'(up_val);
          end
        end
      end
      default: ;
    endcase
  end

  // Advance state on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r      <= '0;
      pos_timer_r <= kpar_pkg::TIMER_RESET;
      neg_timer_r <= kpar_pkg::TIMER_RESET;
      pos_down_r  <= 1'b0;
      neg_down_r  <= 1'b0;
    end else if (in_acc) begin
      axis_r      <= axis_nxt;
      pos_timer_r <= pos_timer_nxt;
      neg_timer_r <= neg_timer_nxt;
      pos_down_r  <= pos_down_nxt;
      neg_down_r  <= neg_down_nxt;
    end
  end

  // Result register: load on accept, hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_axis_r <= axis_nxt;
      out_pos_r  <= pos_down_nxt;
      out_neg_r  <= neg_down_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Axis never leaves the clamp range
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    (axis_r <= 10'sd256) && (axis_r >= -10'sd256))
    else $error("axis outside clamp range");

  // A held key always has a counter within the release window
  a_pos_window: assert property (@(posedge clk) disable iff (!rst_n)
    pos_down_r |-> (pos_timer_r <= kpar_pkg::RELEASE_MS))
    else $error("positive key held past release time");

  a_neg_window: assert property (@(posedge clk) disable iff (!rst_n)
    neg_down_r |-> (neg_timer_r <= kpar_pkg::RELEASE_MS))
    else $error("negative key held past release time");

  // A tick can release a key but never press one; checked for the positive key
  a_tick_no_press: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.cmd && !pos_down_r) |=> !pos_down_r)
    else $error("tick pressed the positive key");

  // Every accepted request leaves a pending result matching the axis and positive key state
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid_r && out_axis_r == axis_r && out_pos_r == pos_down_r))
    else $error("result register does not reflect updated state");
`endif

endmodule

>>> dv/key_pair_axis_ramp_tb.sv
// Self-checking testbench for key_pair_axis_ramp: directed and random
// byte/tick requests checked against an in-bench axis predictor.
// Depends on kpar_pkg, kpar_in_if, kpar_out_if and the key_pair_axis_ramp RTL.
module key_pair_axis_ramp_tb;

  // Generous ceiling: every request waiting out the longest stall on both
  // sides still finishes far below this.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [kpar_pkg::AXIS_W-1:0] axis;
    logic                               pos;
    logic                               neg;
  } axis_sample_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [kpar_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [kpar_pkg::CFG_DATA_W-1:0] cfg_wdata;

  kpar_in_if  req_ch ();
  kpar_out_if res_ch ();

  key_pair_axis_ramp i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the configuration registers
  logic [kpar_pkg::KEY_W-1:0]  up_key;
  logic [kpar_pkg::KEY_W-1:0]  down_key;
  logic [kpar_pkg::STEP_W-1:0] ramp_step;
  logic                        return_home;

  // Predictor copy of the block state
  int          lvl;
  int unsigned up_timer;
  int unsigned down_timer;
  bit          up_held;
  bit          down_held;

  axis_sample_t pending_samples[$];
  int unsigned  error_count;
  int unsigned  cycle_count;

  // Stall controls, set by the tests and honoured by the driving processes
  bit sender_gaps;
  bit sink_stalls;
  int sink_hold_len;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predictor by one request and return the result it shows.
  function automatic axis_sample_t next_axis_sample(kpar_pkg::cmd_t op,
                                                    logic [kpar_pkg::KEY_W-1:0] code,
                                                    logic [kpar_pkg::TIMER_W-1:0] dt);
    int stride;
    axis_sample_t s;
    if (op == kpar_pkg::CMD_BYTE) begin
      // Positive key wins when both keys share a code
      if (code == up_key) begin
        up_held  = 1'b1;
        up_timer = 0;
      end else if (code == down_key) begin
        down_held  = 1'b1;
        down_timer = 0;
      end
    end else begin
      stride = (ramp_step == '0) ? int'(kpar_pkg::DEFAULT_STEP) : int'(ramp_step);
      // Saturate the counters rather than wrap
      up_timer   = (up_timer + dt > kpar_pkg::TIMER_MAX) ? kpar_pkg::TIMER_MAX
                                                         : up_timer + dt;
      down_timer = (down_timer + dt > kpar_pkg::TIMER_MAX) ? kpar_pkg::TIMER_MAX
                                                           : down_timer + dt;
      if (up_timer > kpar_pkg::RELEASE_MS) up_held = 1'b0;
      if (down_timer > kpar_pkg::RELEASE_MS) down_held = 1'b0;
      if (up_held && !down_held) begin
        lvl = lvl + stride;
        if (lvl > int'(kpar_pkg::AXIS_LIMIT)) lvl = int'(kpar_pkg::AXIS_LIMIT);
      end else if (down_held && !up_held) begin
        lvl = lvl - stride;
        if (lvl < -int'(kpar_pkg::AXIS_LIMIT)) lvl = -int'(kpar_pkg::AXIS_LIMIT);
      end else if (return_home) begin
        // Step back towards zero, never past it
        if (lvl > 0) begin
          lvl = lvl - stride;
          if (lvl < 0) lvl = 0;
        end else if (lvl < 0) begin
          lvl = lvl + stride;
          if (lvl > 0) lvl = 0;
        end
      end
    end
    s.axis = lvl[kpar_pkg::AXIS_W-1:0];
    s.pos  = up_held;
    s.neg  = down_held;
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Check each delivered result against the oldest prediction, then log any
  // request taken at this edge. Sample everything at the rising edge.
  always @(posedge clk) begin : scoreboard
    axis_sample_t want;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("result with no request outstanding", int'(res_ch.axis_out), 0);
        end else begin
          want = pending_samples.pop_front();
          if (res_ch.axis_out !== want.axis)
            report_mismatch("axis_out", int'(res_ch.axis_out), int'(want.axis));
          if (res_ch.pos_held !== want.pos)
            report_mismatch("pos_held", int'(res_ch.pos_held), int'(want.pos));
          if (res_ch.neg_held !== want.neg)
            report_mismatch("neg_held", int'(res_ch.neg_held), int'(want.neg));
        end
      end
      if (req_ch.valid && req_ch.ready)
        pending_samples.push_back(next_axis_sample(kpar_pkg::cmd_t'(req_ch.cmd),
                                                   req_ch.rx_byte, req_ch.elapsed_ms));
    end
  end

  // Result sink: drive ready at the falling edge. A long hold-off requested
  // by a test is counted out here; otherwise, with stalls on, stall in short random bursts.
  initial begin : result_sink
    int hold;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_len != 0) begin
        res_ch.ready <= 1'b0;
        hold = sink_hold_len;
        sink_hold_len = 0;
        repeat (hold) @(negedge clk);
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it drags on past the limit.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("key_pair_axis_ramp_tb: FAIL");
    $finish;
  end

  // Offer one request from a falling edge and hold it until taken. Leave
  // valid high afterwards unless a gap follows, so that back-to-back
  // requests never see valid dropped and raised in one step.
  task automatic send_request(kpar_pkg::cmd_t op, logic [kpar_pkg::KEY_W-1:0] code,
                              logic [kpar_pkg::TIMER_W-1:0] dt);
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= op;
    req_ch.rx_byte    <= code;
    req_ch.elapsed_ms <= dt;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has been delivered.
  task automatic await_results();
    req_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all four registers on consecutive edges; call only while idle.
  task automatic apply_settings(logic [kpar_pkg::KEY_W-1:0] pk,
                                logic [kpar_pkg::KEY_W-1:0] nk,
                                logic [kpar_pkg::STEP_W-1:0] stride, logic home);
    cfg_we    <= 1'b1;
    cfg_idx   <= kpar_pkg::REG_POSITIVE_KEY;
    cfg_wdata <= kpar_pkg::CFG_DATA_W'(pk);
    @(negedge clk);
    cfg_idx   <= kpar_pkg::REG_NEGATIVE_KEY;
    cfg_wdata <= kpar_pkg::CFG_DATA_W'(nk);
    @(negedge clk);
    cfg_idx   <= kpar_pkg::REG_STEP_SIZE;
    cfg_wdata <= kpar_pkg::CFG_DATA_W'(stride);
    @(negedge clk);
    cfg_idx   <= kpar_pkg::REG_AUTO_RETURN;
    cfg_wdata <= kpar_pkg::CFG_DATA_W'(home);
    @(negedge clk);
    cfg_we    <= 1'b0;
    up_key      = pk;
    down_key    = nk;
    ramp_step   = stride;
    return_home = home;
  endtask

  // Mostly key presses for the configured keys and short ticks, so that the
  // axis actually ramps, clamps and returns; the rest is stray bytes, long
  // gaps and saturating ticks. Ignored fields still carry random bits.
  task automatic send_random_request();
    int pick;
    int span;
    logic [kpar_pkg::TIMER_W-1:0] dt;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_request(kpar_pkg::CMD_BYTE, up_key, kpar_pkg::TIMER_W'($urandom));
    end else if (pick < 55) begin
      send_request(kpar_pkg::CMD_BYTE, down_key, kpar_pkg::TIMER_W'($urandom));
    end else if (pick < 65) begin
      send_request(kpar_pkg::CMD_BYTE, kpar_pkg::KEY_W'($urandom),
                   kpar_pkg::TIMER_W'($urandom));
    end else begin
      span = $urandom_range(0, 15);
      if (span == 0)      dt = kpar_pkg::TIMER_W'($urandom);
      else if (span == 1) dt = kpar_pkg::TIMER_MAX;
      else if (span < 5)  dt = kpar_pkg::TIMER_W'($urandom_range(100, 400));
      else                dt = kpar_pkg::TIMER_W'($urandom_range(0, 60));
      send_request(kpar_pkg::CMD_TICK, kpar_pkg::KEY_W'($urandom), dt);
    end
  endtask

  // Reset values: both keys on code zero, so the positive key takes the
  // byte; then run the counters to their ceiling.
  task automatic test_reset_defaults();
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    send_request(kpar_pkg::CMD_BYTE, 8'hFF, 16'hFFFF);
    send_request(kpar_pkg::CMD_BYTE, 8'h00, 16'h0000);
    send_request(kpar_pkg::CMD_TICK, 8'hFF, kpar_pkg::RELEASE_MS);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd1);
    send_request(kpar_pkg::CMD_TICK, 8'h00, kpar_pkg::TIMER_MAX);
    send_request(kpar_pkg::CMD_TICK, 8'hFF, kpar_pkg::TIMER_MAX);
    await_results();
  endtask

  // Ramp to both clamps with a wide step; both keys held freezes the axis.
  task automatic test_ramp_and_clamp();
    apply_settings(8'hA5, 8'h5A, 10'd512, 1'b0);
    send_request(kpar_pkg::CMD_BYTE, 8'hA5, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    send_request(kpar_pkg::CMD_BYTE, 8'h5A, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd151);
    send_request(kpar_pkg::CMD_BYTE, 8'h5A, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd10);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    await_results();
  endtask

  // Auto-return with the default step (step register zero), then with the
  // widest step, which must stop at zero rather than cross it.
  task automatic test_auto_return();
    apply_settings(8'hFF, 8'h00, 10'd0, 1'b1);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd200);
    send_request(kpar_pkg::CMD_BYTE, 8'hFF, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd20);
    await_results();
    apply_settings(8'hFF, 8'h00, 10'd1023, 1'b1);
    send_request(kpar_pkg::CMD_BYTE, 8'hFF, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd0);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd151);
    send_request(kpar_pkg::CMD_TICK, 8'h00, 16'd5);
    await_results();
  endtask

  // Random traffic over several settings, the extremes among them. Vary
  // which side idles so that some phases run without gaps on one side.
  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_settings(8'h00, 8'hFF, 10'd1, 1'b1);
        1: apply_settings(kpar_pkg::KEY_W'($urandom), kpar_pkg::KEY_W'($urandom),
                          10'd1023, 1'b0);
        2: apply_settings(8'h3C, 8'h3C, 10'd0, 1'b1);
        3: apply_settings(kpar_pkg::KEY_W'($urandom), kpar_pkg::KEY_W'($urandom),
                          kpar_pkg::STEP_W'($urandom_range(1, 64)), 1'b1);
        default: apply_settings(8'hFF, 8'h00, 10'd512, 1'b0);
      endcase
      sender_gaps = (phase != 1);
      sink_stalls = (phase != 3);
      repeat (200) send_random_request();
      // Pause the sender until the block has caught up
      await_results();
    end
  endtask

  // Hold the sink off for a long stretch while requests keep coming, so the
  // result register fills and the input stalls.
  task automatic test_backpressure();
    apply_settings(kpar_pkg::KEY_W'($urandom), kpar_pkg::KEY_W'($urandom), 10'd32, 1'b1);
    sender_gaps   = 1'b0;
    sink_hold_len = 80;
    repeat (40) send_random_request();
    await_results();
  endtask

  // Finish with full-rate traffic: no idling on either side.
  task automatic test_full_rate_tail();
    apply_settings(kpar_pkg::KEY_W'($urandom), kpar_pkg::KEY_W'($urandom),
                   kpar_pkg::STEP_W'($urandom_range(1, 512)), 1'($urandom));
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (100) send_random_request();
    await_results();
  endtask

  initial begin : run
    // Drive every input to a known value from time zero
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = kpar_pkg::REG_POSITIVE_KEY;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = kpar_pkg::CMD_BYTE;
    req_ch.rx_byte    = '0;
    req_ch.elapsed_ms = '0;
    sender_gaps       = 1'b1;
    sink_stalls       = 1'b1;
    sink_hold_len     = 0;
    error_count       = 0;
    // Predictor starts from the reset state of the block
    up_key      = '0;
    down_key    = '0;
    ramp_step   = kpar_pkg::DEFAULT_STEP;
    return_home = 1'b0;
    lvl         = 0;
    up_timer    = kpar_pkg::TIMER_RESET;
    down_timer  = kpar_pkg::TIMER_RESET;
    up_held     = 1'b0;
    down_held   = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_ramp_and_clamp();
    test_auto_return();
    test_random_phases();
    test_backpressure();
    test_full_rate_tail();

    // Spare edges at the end catch any stray result
    repeat (4) @(posedge clk);
    if (pending_samples.size() != 0)
      report_mismatch("requests left without a result", pending_samples.size(), 0);
    if (error_count == 0) begin
      $display("key_pair_axis_ramp_tb: PASS");
    end else begin
      $display("key_pair_axis_ramp_tb: FAIL");
    end
    $finish;
  end

endmodule
